/* rtl/sfr_pkg.sv */
// sfr_pkg: shared constants, controller states and command/status types
// for the stream find-and-replace block; no dependencies
`default_nettype none

package sfr_pkg;

  localparam int NEEDLE_MAX  = 8;
  localparam int REPLACE_MAX = 8;
  localparam int WIN_CAP     = 8;

  localparam int BYTE_W  = 8;
  localparam int REG_W   = 64;
  localparam int LEN_W   = 4;
  localparam int CNT_W   = $clog2(WIN_CAP + 1);
  localparam int IDX_W   = $clog2(WIN_CAP);
  localparam int CIDX_W  = 2;

  localparam int N_LIM_I = (NEEDLE_MAX  < WIN_CAP) ? NEEDLE_MAX  : WIN_CAP;
  localparam int R_LIM_I = (REPLACE_MAX < WIN_CAP) ? REPLACE_MAX : WIN_CAP;
  localparam logic [LEN_W-1:0] N_LIM = LEN_W'(N_LIM_I);
  localparam logic [LEN_W-1:0] R_LIM = LEN_W'(R_LIM_I);

  localparam logic [CIDX_W-1:0] REG_NEEDLE_BYTES       = 2'd0;
  localparam logic [CIDX_W-1:0] REG_NEEDLE_LENGTH      = 2'd1;
  localparam logic [CIDX_W-1:0] REG_REPLACEMENT_BYTES  = 2'd2;
  localparam logic [CIDX_W-1:0] REG_REPLACEMENT_LENGTH = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROOM,
    ST_PUSH,
    ST_SCAN,
    ST_REPL,
    ST_FLUSH,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic take_in;
    logic pop_emit;
    logic push;
    logic rep_start;
    logic rep_emit;
    logic finish;
  } sfr_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic room_pop;
    logic full_match;
    logic partial;
    logic rep_more;
    logic can_gen;
    logic out_free;
    logic item_last;
  } sfr_status_t;

endpackage

`default_nettype wire

/* rtl/sfr_if.sv */
// sfr_if: valid/ready stream interfaces for input text beats and result beats
// no dependencies
`default_nettype none

interface sfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source(output valid, output in_byte, output in_last, input ready);
  modport sink(input valid, input in_byte, input in_last, output ready);
endinterface

interface sfr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       out_last;

  modport source(output valid, output out_byte, output byte_valid, output out_last,
                 input ready);
  modport sink(input valid, input out_byte, input byte_valid, input out_last,
               output ready);
endinterface

`default_nettype wire

/* rtl/stream_find_replace.sv */
// stream_find_replace: top level joining controller and datapath
// depends on sfr_pkg, sfr_if, sfr_ctrl, sfr_datapath
//
// One text beat is taken at a time, and the next beat is accepted only once
// the block is through with the last one. All results, pass-through bytes and
// replacement bytes alike, leave one per cycle unless the result side stalls,
// through a single output register fed by a one-beat hold stage. The hold stage
// lets the block mark the last result of a string, or send an empty end
// marker when a string's final beat releases no byte. Configuration writes
// are taken at any time but belong between beats, while the block is idle;
// a change in the middle of a string is handled.
`default_nettype none

module stream_find_replace
  import sfr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  sfr_in_if.sink                 in,
  sfr_out_if.source              out,
  input  wire logic              cfg_write,
  input  wire logic [CIDX_W-1:0] cfg_index,
  input  wire logic [REG_W-1:0]  cfg_data
);

  sfr_cmd_t    cmd;
  sfr_status_t status;
  logic        in_ready;

  assign in.ready = in_ready;

  sfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  sfr_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_byte    (in.in_byte),
    .in_last    (in.in_last),
    .cmd        (cmd),
    .status     (status),
    .out_valid  (out.valid),
    .out_ready  (out.ready),
    .out_byte   (out.out_byte),
    .byte_valid (out.byte_valid),
    .out_last   (out.out_last)
  );

endmodule

`default_nettype wire

/* rtl/sfr_ctrl.sv */
// sfr_ctrl: controller state machine sequencing one input beat at a time
// depends on sfr_pkg
`default_nettype none

module sfr_ctrl
  import sfr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire sfr_status_t status,
  output sfr_cmd_t         cmd
);

  state_t state;
  state_t state_next;
  state_t route;

  assign route = status.item_last ? ST_FLUSH : ST_FIN;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_ROOM;
      end
      ST_ROOM: begin
        if (!status.room_pop) state_next = ST_PUSH;
      end
      ST_PUSH: state_next = ST_SCAN;
      ST_SCAN: begin
        if (status.cnt_zero) state_next = route;
        else if (status.full_match) state_next = ST_REPL;
        else if (status.partial) state_next = route;
      end
      ST_REPL: begin
        if (!status.rep_more) state_next = route;
      end
      ST_FLUSH: begin
        if (status.cnt_zero) state_next = ST_FIN;
      end
      ST_FIN: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready    = !rst;
        cmd.take_in = in_valid && !rst;
      end
      ST_ROOM: begin
        cmd.pop_emit = status.room_pop && status.can_gen;
      end
      ST_PUSH: cmd.push = 1'b1;
      ST_SCAN: begin
        if (!status.cnt_zero) begin
          if (status.full_match) cmd.rep_start = 1'b1;
          else if (!status.partial) cmd.pop_emit = status.can_gen;
        end
      end
      ST_REPL: begin
        cmd.rep_emit = status.rep_more && status.can_gen;
      end
      ST_FLUSH: begin
        cmd.pop_emit = !status.cnt_zero && status.can_gen;
      end
      ST_FIN: cmd.finish = status.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/sfr_datapath.sv */
// sfr_datapath: configuration registers, pending window, replacement index,
// one-beat hold stage and output register; depends on sfr_pkg
`default_nettype none

module sfr_datapath
  import sfr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_write,
  input  wire logic [CIDX_W-1:0] cfg_index,
  input  wire logic [REG_W-1:0]  cfg_data,
  input  wire logic [BYTE_W-1:0] in_byte,
  input  wire logic              in_last,
  input  wire sfr_cmd_t          cmd,
  output sfr_status_t            status,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [BYTE_W-1:0]      out_byte,
  output logic                   byte_valid,
  output logic                   out_last
);

  logic [REG_W-1:0]  needle_bytes;
  logic [LEN_W-1:0]  needle_length;
  logic [REG_W-1:0]  replacement_bytes;
  logic [LEN_W-1:0]  replacement_length;

  logic [BYTE_W-1:0] window [WIN_CAP];
  logic [CNT_W-1:0]  count;
  logic [LEN_W-1:0]  rep_idx;
  logic [BYTE_W-1:0] item_byte;
  logic              item_last;
  logic [BYTE_W-1:0] hold_byte;
  logic              hold_v;

  logic [LEN_W-1:0]  nlen;
  logic [LEN_W-1:0]  rlen;
  logic [LEN_W-1:0]  count_l;
  logic [WIN_CAP-1:0] match;
  logic              prefix;
  logic              gen;
  logic [BYTE_W-1:0] gen_byte;
  logic              out_free;
  logic              load_out;

  assign nlen    = (needle_length > N_LIM) ? N_LIM : needle_length;
  assign rlen    = (replacement_length > R_LIM) ? R_LIM : replacement_length;
  assign count_l = LEN_W'(count);

  always_comb begin
    for (int i = 0; i < WIN_CAP; i++) begin
      match[i] = (CNT_W'(i) >= count) || (window[i] == needle_bytes[i*BYTE_W +: BYTE_W]);
    end
  end
  assign prefix = &match;

  assign out_free = !out_valid || out_ready;
  assign gen      = cmd.pop_emit || cmd.rep_emit;
  assign gen_byte = cmd.rep_emit ? replacement_bytes[rep_idx[IDX_W-1:0]*BYTE_W +: BYTE_W]
                                 : window[0];
  assign load_out = (gen && hold_v) || (cmd.finish && (hold_v || item_last));

  assign status.cnt_zero   = (count == '0);
  assign status.room_pop   = (count != '0) && ((count_l >= nlen) || !prefix);
  assign status.full_match = (count_l == nlen) && prefix;
  assign status.partial    = (count_l < nlen) && prefix;
  assign status.rep_more   = (rep_idx < rlen);
  assign status.can_gen    = !hold_v || out_free;
  assign status.out_free   = out_free;
  assign status.item_last  = item_last;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      needle_bytes       <= '0;
      needle_length      <= LEN_W'(1);
      replacement_bytes  <= '0;
      replacement_length <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_NEEDLE_BYTES:       needle_bytes       <= cfg_data;
        REG_NEEDLE_LENGTH:      needle_length      <= cfg_data[LEN_W-1:0];
        REG_REPLACEMENT_BYTES:  replacement_bytes  <= cfg_data;
        REG_REPLACEMENT_LENGTH: replacement_length <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // window fill count and hold/output valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      hold_v    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.pop_emit) count <= count - CNT_W'(1);
      else if (cmd.push) count <= count + CNT_W'(1);
      else if (cmd.rep_start) count <= '0;

      if (gen) hold_v <= 1'b1;
      else if (cmd.finish) hold_v <= 1'b0;

      if (load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      item_byte <= in_byte;
      item_last <= in_last;
    end
    if (cmd.pop_emit) begin
      for (int i = 0; i < WIN_CAP - 1; i++) window[i] <= window[i+1];
    end else if (cmd.push) begin
      window[count[IDX_W-1:0]] <= item_byte;
    end
    if (cmd.rep_start) rep_idx <= '0;
    else if (cmd.rep_emit) rep_idx <= rep_idx + LEN_W'(1);
    if (gen) hold_byte <= gen_byte;
    if (load_out) begin
      out_byte   <= hold_v ? hold_byte : '0;
      byte_valid <= hold_v;
      out_last   <= cmd.finish && item_last;
    end
  end

endmodule

`default_nettype wire

/* bench/tb.sv */
// tb: self-checking bench for stream_find_replace, directed strings then random text
// under changing needle and replacement settings, with a class that tracks the rewritten text
// depends on sfr_pkg, sfr_if and stream_find_replace
module tb
  import sfr_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 30;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASES        = 9;
  localparam int PHASE_BEATS   = 44;

  typedef struct {
    logic [7:0] text;
    logic       has_byte;
    logic       ends_string;
  } text_beat_t;

  class rewrite_tracker;
    logic [REG_W-1:0] needle;
    logic [LEN_W-1:0] needle_len;
    logic [REG_W-1:0] repl;
    logic [LEN_W-1:0] repl_len;
    logic [7:0]       window [WIN_CAP];
    int               held;
    text_beat_t       rewritten [$];
    int               mismatches;
    int               beats_checked;

    function new();
      needle = '0;
      needle_len = LEN_W'(1);
      repl = '0;
      repl_len = '0;
      held = 0;
      mismatches = 0;
      beats_checked = 0;
      foreach (window[i]) window[i] = '0;
    endfunction

    function void write_reg(logic [CIDX_W-1:0] idx, logic [REG_W-1:0] data);
      case (idx)
        REG_NEEDLE_BYTES:       needle = data;
        REG_NEEDLE_LENGTH:      needle_len = data[LEN_W-1:0];
        REG_REPLACEMENT_BYTES:  repl = data;
        REG_REPLACEMENT_LENGTH: repl_len = data[LEN_W-1:0];
        default: ;
      endcase
    endfunction

    function bit window_on_needle();
      for (int i = 0; i < held; i++)
        if (window[i] != needle[8*i +: 8]) return 1'b0;
      return 1'b1;
    endfunction

    function void emit(logic [7:0] b, logic v);
      text_beat_t t;
      t.text = b;
      t.has_byte = v;
      t.ends_string = 1'b0;
      rewritten.push_back(t);
    endfunction

    function void release_front();
      emit(window[0], 1'b1);
      for (int i = 0; i < WIN_CAP - 1; i++) window[i] = window[i+1];
      held--;
    endfunction

    function void take_text_beat(logic [7:0] b, logic last);
      int nlen;
      int rlen;
      int start_size;
      text_beat_t tail;
      nlen = (needle_len > N_LIM_I) ? N_LIM_I : int'(needle_len);
      rlen = (repl_len > R_LIM_I) ? R_LIM_I : int'(repl_len);
      start_size = rewritten.size();
      // window must stay a proper prefix of the needle now in force
      while (held > 0 && (held >= nlen || !window_on_needle())) release_front();
      window[held] = b;
      held++;
      while (held > 0) begin
        if (held == nlen && window_on_needle()) begin
          for (int i = 0; i < rlen; i++) emit(repl[8*i +: 8], 1'b1);
          held = 0;
        end else if (held < nlen && window_on_needle()) begin
          break;
        end else begin
          release_front();
        end
      end
      if (last) begin
        while (held > 0) release_front();
        if (rewritten.size() == start_size) emit(8'h00, 1'b0);
        tail = rewritten.pop_back();
        tail.ends_string = 1'b1;
        rewritten.push_back(tail);
      end
    endfunction

    function void note_mismatch(string msg);
      if (mismatches < 10) $display("mismatch: %s", msg);
      mismatches++;
    endfunction

    function void check_rewritten_beat(logic [7:0] b, logic v, logic last);
      text_beat_t want;
      beats_checked++;
      if (rewritten.size() == 0) begin
        note_mismatch($sformatf("unexpected beat byte=%02h valid=%0b last=%0b", b, v, last));
        return;
      end
      want = rewritten.pop_front();
      if (b !== want.text || v !== want.has_byte || last !== want.ends_string)
        note_mismatch($sformatf("beat %0d want byte=%02h valid=%0b last=%0b got byte=%02h valid=%0b last=%0b",
                                beats_checked, want.text, want.has_byte, want.ends_string,
                                b, v, last));
    endfunction

    function void close_out();
      while (rewritten.size() != 0) begin
        note_mismatch($sformatf("beat byte=%02h never arrived", rewritten[0].text));
        void'(rewritten.pop_front());
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_write;
  logic [CIDX_W-1:0]   cfg_index;
  logic [REG_W-1:0]    cfg_data;

  int   tx_idle_pct = 21;
  int   rx_idle_pct = 58;
  logic hold_armed = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;
  int   cycle_count = 0;
  int   beats_sent = 0;
  int   strings_sent = 0;
  int   configs_applied = 0;

  rewrite_tracker tracker = new();

  sfr_in_if  text_in ();
  sfr_out_if text_out ();

  stream_find_replace dut (
    .clk       (clk),
    .rst       (rst),
    .in        (text_in),
    .out       (text_out),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5ns clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (!rst && text_out.valid && text_out.ready)
      tracker.check_rewritten_beat(text_out.out_byte, text_out.byte_valid, text_out.out_last);
    if (hold_left > 0) begin
      text_out.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_armed && !hold_done) begin
      text_out.ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      text_out.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [REG_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    tracker.write_reg(idx, data);
  endtask

  task automatic load_config(logic [REG_W-1:0] nb, logic [REG_W-1:0] nl,
                             logic [REG_W-1:0] rb, logic [REG_W-1:0] rl);
    write_reg(REG_NEEDLE_BYTES, nb);
    write_reg(REG_NEEDLE_LENGTH, nl);
    write_reg(REG_REPLACEMENT_BYTES, rb);
    write_reg(REG_REPLACEMENT_LENGTH, rl);
    cfg_write <= 1'b0;
    configs_applied++;
  endtask

  task automatic send_beat(logic [7:0] b, logic last);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      text_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    text_in.valid <= 1'b1;
    text_in.in_byte <= b;
    text_in.in_last <= last;
    do @(posedge clk); while (!text_in.ready);
    tracker.take_text_beat(b, last);
    beats_sent++;
    if (last) strings_sent++;
  endtask

  task automatic send_string(logic [7:0] s [$], bit close);
    for (int i = 0; i < s.size(); i++)
      send_beat(s[i], close && (i == s.size() - 1));
  endtask

  // let all results drain, then give the block time to go idle
  task automatic settle();
    text_in.valid <= 1'b0;
    while (tracker.rewritten.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(int nlen_pick, int rlen_pick, bit leave_open);
    logic [7:0]       alpha [3];
    logic [7:0]       txt [$];
    logic [REG_W-1:0] nb;
    logic [REG_W-1:0] rb;
    int               nlen;
    int               rlen;
    int               eff;
    int               target;
    int               pick;
    int               plen;
    int               sent;
    bit               close;
    foreach (alpha[i]) alpha[i] = 8'($urandom_range(255));
    for (int i = 0; i < 8; i++) nb[8*i +: 8] = alpha[$urandom_range(2)];
    rb = {$urandom, $urandom};
    nlen = nlen_pick;
    if (nlen < 0) begin
      pick = $urandom_range(99);
      nlen = (pick < 8) ? 0 : (pick < 16) ? $urandom_range(9, 15) : $urandom_range(1, 8);
    end
    rlen = rlen_pick;
    if (rlen < 0) begin
      pick = $urandom_range(99);
      rlen = (pick < 10) ? 0 : (pick < 18) ? $urandom_range(9, 15) : $urandom_range(0, 8);
    end
    eff = (nlen > N_LIM_I) ? N_LIM_I : (nlen == 0) ? 1 : nlen;
    settle();
    load_config(nb, {$urandom, 28'($urandom), 4'(nlen)}, rb, {$urandom, 28'($urandom), 4'(rlen)});
    // long output hold-off while text keeps coming
    if (!hold_done) hold_armed <= 1'b1;
    sent = 0;
    while (sent < PHASE_BEATS) begin
      txt.delete();
      target = $urandom_range(1, 14);
      while (txt.size() < target) begin
        pick = $urandom_range(99);
        if (pick < 40) begin
          for (int k = 0; k < eff; k++) txt.push_back(nb[8*k +: 8]);
        end else if (pick < 60) begin
          plen = $urandom_range(1, eff);
          for (int k = 0; k < plen; k++) txt.push_back(nb[8*k +: 8]);
        end else if (pick < 88) begin
          txt.push_back(alpha[$urandom_range(2)]);
        end else begin
          txt.push_back(8'($urandom_range(255)));
        end
      end
      sent += txt.size();
      close = !(leave_open && sent >= PHASE_BEATS);
      send_string(txt, close);
    end
  endtask

  initial begin
    logic [7:0] s [$];
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= REG_NEEDLE_BYTES;
    cfg_data <= '0;
    text_in.valid <= 1'b0;
    text_in.in_byte <= '0;
    text_in.in_last <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset settings delete every zero byte
    s = '{8'h00};
    send_string(s, 1'b1);
    s = '{8'hFF};
    send_string(s, 1'b1);

    // zero byte mid-string, match, and a prefix flushed at the end
    settle();
    load_config(64'h636261, 64'h3, 64'h5958, 64'h2);
    s = '{8'h61, 8'h00, 8'h61, 8'h62, 8'h63, 8'h61, 8'h62};
    send_string(s, 1'b1);

    // needle changed while a prefix is held
    s = '{8'h61, 8'h62};
    send_string(s, 1'b0);
    settle();
    load_config(64'h7A62, 64'h2, 64'h0, 64'h0);
    s = '{8'h7A};
    send_string(s, 1'b1);

    // oversized lengths clamp to the window size
    settle();
    load_config(64'hFFFF_FFFF_FFFF_FFFF, 64'hF, 64'h0123_4567_89AB_CDEF, 64'hF);
    s = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_string(s, 1'b1);
    s = '{8'hFF, 8'hFF, 8'hFF, 8'h00};
    send_string(s, 1'b1);

    // zero-length needle passes everything
    settle();
    load_config(64'h5A, 64'h0, 64'h1, 64'h1);
    s = '{8'h5A, 8'h00};
    send_string(s, 1'b1);

    for (int p = 0; p < PHASES; p++) begin
      if (p == 3) begin
        tx_idle_pct <= 58;
        rx_idle_pct <= 21;
      end
      if (p == 6) begin
        tx_idle_pct <= 0;
        rx_idle_pct <= 0;
      end
      run_phase((p == 3) ? 8 : (p == 6) ? 1 : -1,
                (p == 3) ? 15 : (p == 6) ? 8 : -1,
                (p != PHASES - 1) && ($urandom_range(1) == 1));
    end

    settle();
    tracker.close_out();
    $display("sent %0d text beats in %0d strings under %0d register settings",
             beats_sent, strings_sent, configs_applied);
    $display("checked %0d result beats, including a %0d-cycle output stall",
             tracker.beats_checked, HOLD_CYCLES);
    if (tracker.mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches", tracker.mismatches);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
